// File: design/smf_pkg.sv
// ----------------------------------------------------------------------------
// smf_pkg: shared constants and types of the sliding window median filter
// The window depth, sample width and the word that each cell shows to its
// neighbors are defined here.
// ----------------------------------------------------------------------------
package smf_pkg;

  localparam int WINDOW       = 16;
  localparam int SAMPLE_WIDTH = 16;
  localparam int DATA_W       = 16;
  localparam int EXT_W        = (SAMPLE_WIDTH > DATA_W) ? SAMPLE_WIDTH : DATA_W;
  localparam int IDX_W        = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W        = $clog2(WINDOW + 1);

  typedef logic [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    sample_t value;
    sample_t hist;
    logic    valid;
    logic    gt;
    logic    ge;
  } cell_t;

endpackage

// File: design/smf_cell.sv
// ----------------------------------------------------------------------------
// smf_cell: one position of the sorted window
// Holds one sorted entry and one tap of the sample history. On each word it
// takes its new entry from itself, a neighbor or the incoming sample.
// ----------------------------------------------------------------------------
module smf_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             full_i,
  input  smf_pkg::sample_t x_i,
  input  smf_pkg::sample_t r_i,
  input  smf_pkg::cell_t   lo_i,
  input  smf_pkg::cell_t   hi_i,
  output smf_pkg::cell_t   cell_o
);

  smf_pkg::sample_t value_q, value_d;
  smf_pkg::sample_t hist_q;
  logic             valid_q;
  logic             gt, ge;
  logic             b_self, b_lo;
  smf_pkg::sample_t w_self, w_lo;

  // The entry being retired is the lowest copy of the oldest sample, so every
  // cell at or above it reads its list position from the cell above.
  assign gt = !valid_q || (value_q > x_i);
  assign ge = full_i && (value_q >= r_i);

  assign w_self = ge ? hi_i.value : value_q;
  assign b_self = ge ? hi_i.gt : gt;
  assign w_lo   = lo_i.ge ? value_q : lo_i.value;
  assign b_lo   = lo_i.ge ? gt : lo_i.gt;

  always_comb begin
    priority if (!b_self) begin
      value_d = w_self;
    end else if (!b_lo) begin
      value_d = x_i;
    end else begin
      value_d = w_lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_q | lo_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_q <= value_d;
      hist_q  <= lo_i.hist;
    end
  end

  assign cell_o = '{value: value_q, hist: hist_q, valid: valid_q, gt: gt, ge: ge};

endmodule

// File: design/smf_median.sv
// ----------------------------------------------------------------------------
// smf_median: median selection
// Picks the middle entry, or the floored mean of the two middle entries,
// from the sorted row according to the number of held samples.
// ----------------------------------------------------------------------------
module smf_median (
  input  smf_pkg::sample_t [smf_pkg::WINDOW-1:0] values_i,
  input  logic [smf_pkg::CNT_W-1:0]              count_i,
  output logic [smf_pkg::DATA_W-1:0]             median_o
);

  logic [smf_pkg::CNT_W-1:0]      mid, lo_full;
  logic [smf_pkg::IDX_W-1:0]      hi_idx, lo_idx;
  logic [smf_pkg::SAMPLE_WIDTH:0] sum;
  smf_pkg::sample_t               med;
  logic [smf_pkg::EXT_W-1:0]      med_ext;

  // With an odd count both indexes point at the middle entry.
  assign mid     = count_i >> 1;
  assign lo_full = mid - smf_pkg::CNT_W'(!count_i[0]);
  assign hi_idx  = mid[smf_pkg::IDX_W-1:0];
  assign lo_idx  = lo_full[smf_pkg::IDX_W-1:0];

  assign sum      = {1'b0, values_i[lo_idx]} + {1'b0, values_i[hi_idx]};
  assign med      = sum[smf_pkg::SAMPLE_WIDTH:1];
  assign med_ext  = smf_pkg::EXT_W'(med);
  assign median_o = med_ext[smf_pkg::DATA_W-1:0];

endmodule

// File: design/sliding_window_median_filter_top.sv
// ----------------------------------------------------------------------------
// sliding_window_median_filter_top: streaming sliding window median filter
// A row of cells keeps the last WINDOW samples sorted and drops the oldest
// one as each new sample comes in; the median is taken from the middle.
//
//   Channel  Dir  Fields (lowest bit first)
//   s_axis   in   tdata: sample[15:0]
//   m_axis   out  tdata: median[15:0]; tuser: window_full
//
// Each sample is sorted into the cell row at the edge that accepts it, and
// its median is registered into the output word once m_axis has room for it.
// One sample per cycle is sustained while m_axis drains.
// Reset empties the window. A stalled output holds its word, and the input
// stalls only once a second computed median has no room.
// ----------------------------------------------------------------------------
module sliding_window_median_filter_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // sample[15:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // median[15:0]
  output logic        m_axis_tuser    // window_full
);

  localparam int W = smf_pkg::WINDOW;

  smf_pkg::cell_t                 cells [W];
  smf_pkg::sample_t [W-1:0]       values;
  logic [smf_pkg::EXT_W-1:0]      in_ext;
  smf_pkg::sample_t               x;
  logic                           full;
  logic                           accept, out_free, load;
  logic                           pend_q, m_valid_q, m_full_q;
  logic [smf_pkg::CNT_W-1:0]      cnt_q;
  logic [smf_pkg::DATA_W-1:0]     median, m_data_q;
  smf_pkg::cell_t                 edge_lo, edge_hi;

  assign in_ext = smf_pkg::EXT_W'(s_axis_tdata);
  assign x      = in_ext[smf_pkg::SAMPLE_WIDTH-1:0];
  assign full   = cells[W-1].valid;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign load          = pend_q && out_free;
  assign s_axis_tready = !pend_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign edge_lo = '{value: '0, hist: x, valid: 1'b1, gt: 1'b0, ge: 1'b0};
  assign edge_hi = '{value: '0, hist: '0, valid: 1'b0, gt: 1'b1, ge: 1'b1};

  for (genvar i = 0; i < W; i++) begin : g_cell
    smf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (accept),
      .full_i (full),
      .x_i    (x),
      .r_i    (cells[W-1].hist),
      .lo_i   ((i == 0) ? edge_lo : cells[(i == 0) ? 0 : i - 1]),
      .hi_i   ((i == W - 1) ? edge_hi : cells[(i == W - 1) ? i : i + 1]),
      .cell_o (cells[i])
    );
    assign values[i] = cells[i].value;
  end

  smf_median u_median (
    .values_i (values),
    .count_i  (cnt_q),
    .median_o (median)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (accept) begin
        pend_q <= 1'b1;
      end else if (out_free) begin
        pend_q <= 1'b0;
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (accept && (cnt_q != smf_pkg::CNT_W'(W))) begin
        cnt_q <= cnt_q + smf_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_data_q <= median;
      m_full_q <= (cnt_q == smf_pkg::CNT_W'(W));
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_full_q;

endmodule

// File: tb/tb_sliding_window_median_filter_top.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_median_filter_top: stream test of the median filter
// Samples enter through s_axis with random gaps, and m_axis stalls at random.
// The bench keeps its own sorted window with ages and checks every median
// word and its window-full flag against the oldest predicted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sliding_window_median_filter_top;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] median;
    logic        full;
  } median_word_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  smf_pkg::sample_t win_vals [smf_pkg::WINDOW];
  int unsigned      win_ages [smf_pkg::WINDOW];
  int unsigned      win_fill;
  median_word_t     expected_medians [$];
  median_word_t     head_word;

  bit          idle_on     = 1'b0;
  int          ready_hold  = 0;
  int          err_count   = 0;
  int          samples_in  = 0;
  int          words_out   = 0;
  int          full_words  = 0;
  int          cycle_count = 0;
  logic [15:0] ramp_value  = '0;

  sliding_window_median_filter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int idle_length();
    if ($urandom_range(0, 99) < 80) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic void swap_entries(int a, int b);
    smf_pkg::sample_t tv;
    int unsigned      ta;
    tv          = win_vals[a];
    ta          = win_ages[a];
    win_vals[a] = win_vals[b];
    win_ages[a] = win_ages[b];
    win_vals[b] = tv;
    win_ages[b] = ta;
  endfunction

  // The new sample takes the expired entry, then bubbles up past entries not
  // above it, or else down past entries above it.
  function automatic median_word_t predict_median(logic [15:0] raw);
    smf_pkg::sample_t               v;
    int                             slot;
    int                             shifts;
    int                             h;
    logic [smf_pkg::SAMPLE_WIDTH:0] pair_sum;
    median_word_t                   w;
    v      = smf_pkg::sample_t'(raw);
    slot   = smf_pkg::WINDOW;
    shifts = 0;
    for (int i = 0; i < smf_pkg::WINDOW; i++) begin
      if (win_ages[i] > 0) begin
        win_ages[i]--;
      end else if (slot == smf_pkg::WINDOW) begin
        slot        = i;
        win_vals[i] = v;
        win_ages[i] = smf_pkg::WINDOW - 1;
      end
    end
    if (slot == smf_pkg::WINDOW) begin
      slot = smf_pkg::WINDOW - 1;
    end
    if (win_fill < smf_pkg::WINDOW) begin
      win_fill++;
    end
    for (int i = slot + 1; i < win_fill; i++) begin
      if (win_vals[i-1] < win_vals[i]) begin
        break;
      end
      swap_entries(i - 1, i);
      shifts++;
    end
    if (shifts == 0) begin
      for (int i = slot; i > 0; i--) begin
        if (win_vals[i] < win_vals[i-1]) begin
          swap_entries(i - 1, i);
        end
      end
    end
    if (win_fill % 2 == 1) begin
      w.median = 16'(win_vals[(win_fill / 2) % smf_pkg::WINDOW]);
    end else begin
      h        = win_fill / 2;
      pair_sum = {1'b0, win_vals[(h - 1) % smf_pkg::WINDOW]}
                 + win_vals[h % smf_pkg::WINDOW];
      w.median = 16'(pair_sum >> 1);
    end
    w.full = (win_fill == smf_pkg::WINDOW);
    return w;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_medians.push_back(predict_median(s_axis_tdata));
        samples_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_medians.size() == 0) begin
          $error("median word 0x%04h arrived with no sample pending", m_axis_tdata);
          err_count++;
        end else begin
          head_word = expected_medians.pop_front();
          words_out++;
          if (m_axis_tuser) begin
            full_words++;
          end
          if (m_axis_tdata !== head_word.median) begin
            $error("median mismatch: expected %0d, actual %0d", head_word.median,
                   m_axis_tdata);
            err_count++;
          end
          if (m_axis_tuser !== head_word.full) begin
            $error("window_full mismatch: expected %0d, actual %0d", head_word.full,
                   m_axis_tuser);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!idle_on) begin
      ready_hold = 0;
      m_axis_tready <= 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      ready_hold = idle_length() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_sample(input logic [15:0] smp);
    int gap;
    s_axis_tdata  <= smp;
    s_axis_tvalid <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    gap = 0;
    if (idle_on && $urandom_range(0, 99) < 30) begin
      gap = idle_length();
    end
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic apply_reset();
    for (int i = 0; i < smf_pkg::WINDOW; i++) begin
      win_vals[i] = '0;
      win_ages[i] = 0;
    end
    win_fill = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
  endtask

  // The first sixteen samples fill the window, so every count from one to
  // full is checked, with maximal pairs that need the wider sum.
  task automatic test_window_fill();
    idle_on = 1'b1;
    send_sample(16'hFFFF);
    send_sample(16'hFFFF);
    send_sample(16'h0000);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h0001);
    send_sample(16'hFFFE);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h1234);
    send_sample(16'h8001);
    send_sample(16'h00FF);
    send_sample(16'hFF00);
    send_sample(16'h7FFE);
  endtask

  task automatic test_equal_samples();
    idle_on = 1'b0;
    repeat (5) send_sample(16'h4242);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h4242);
  endtask

  task automatic test_random_stream();
    logic [15:0] smp;
    int          kind;
    for (int blk = 0; blk < 8; blk++) begin
      idle_on = (blk % 3 != 1);
      kind    = (blk + $urandom_range(0, 1)) % 5;
      for (int n = 0; n < 100; n++) begin
        if ($urandom_range(0, 3) == 0) begin
          smp = 16'($urandom);
        end else begin
          case (kind)
            0: smp = 16'($urandom);
            1: smp = 16'($urandom_range(0, 3) * 16'h5555);
            2: smp = 16'hFFFF - 16'($urandom_range(0, 7));
            3: begin
              ramp_value = ramp_value + 16'($urandom_range(0, 700));
              smp        = ramp_value;
            end
            default: begin
              ramp_value = ramp_value - 16'($urandom_range(0, 700));
              smp        = ramp_value;
            end
          endcase
        end
        send_sample(smp);
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    apply_reset();
    test_window_fill();
    test_equal_samples();
    test_random_stream();
    while (expected_medians.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);
    $display("Sent %0d samples and checked %0d medians, %0d of them with a full window.",
             samples_in, words_out, full_words);
    $display("Covered window filling, repeated values and random streams with stalls.");
    if (err_count == 0 && expected_medians.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
